// ===== hw/rtl/chart_point_to_pixel_scaler_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the chart point scaler
// Immediate-next and same-cycle implication checks, compiled out when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef CHART_POINT_TO_PIXEL_SCALER_MACROS_SVH
`define CHART_POINT_TO_PIXEL_SCALER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CPPS_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);
`define CPPS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CPPS_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg)
`define CPPS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/cpps_pkg.sv =====
// ----------------------------------------------------------------------------
// cpps_pkg
// Widths, register codes, pipeline depths and shared types of the chart
// point scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package cpps_pkg;

	// Fixed-point formats
	localparam int FRAC_BITS     = 16;
	localparam int LOG_FRAC_BITS = 16;

	// Field widths
	localparam int PT_W   = 32;
	localparam int BOX_W  = 16;
	localparam int DIM_W  = 15;
	localparam int SPAN_W = 31;
	localparam int MODE_W = 2;
	localparam int IDX_W  = 3;
	localparam int PIX_W  = 16;
	localparam int STAT_W = 2;

	// Internal widths
	localparam int EXP_W   = 7;
	localparam int LOG_W   = EXP_W + LOG_FRAC_BITS;
	localparam int MANT_W  = 31;
	localparam int VAL_W   = PT_W + 1;
	localparam int QUOT_W  = 16;
	localparam int NUM_W   = 51;
	localparam int YB_W    = BOX_W + 1;

	// Pipeline depths
	localparam int LOG_STAGES = LOG_FRAC_BITS + 1;
	localparam int DIV_STAGES = QUOT_W + 3;
	localparam int PIPE_DEPTH = LOG_STAGES + DIV_STAGES + 2;
	localparam int FIFO_DEPTH = 2;

	// 1.0 in data format
	localparam logic signed [PT_W-1:0] ONE_S = PT_W'(1) << FRAC_BITS;
	localparam logic [SPAN_W-1:0]      ONE_U = SPAN_W'(1) << FRAC_BITS;

	// Register indexes
	localparam logic [IDX_W-1:0] CFG_BOX_LEFT   = 3'd0;
	localparam logic [IDX_W-1:0] CFG_BOX_TOP    = 3'd1;
	localparam logic [IDX_W-1:0] CFG_BOX_WIDTH  = 3'd2;
	localparam logic [IDX_W-1:0] CFG_BOX_HEIGHT = 3'd3;
	localparam logic [IDX_W-1:0] CFG_X_SPAN     = 3'd4;
	localparam logic [IDX_W-1:0] CFG_Y_SPAN     = 3'd5;
	localparam logic [IDX_W-1:0] CFG_AXIS_MODE  = 3'd6;

	// Register reset values
	localparam logic [BOX_W-1:0]  RST_BOX_LEFT   = '0;
	localparam logic [BOX_W-1:0]  RST_BOX_TOP    = '0;
	localparam logic [DIM_W-1:0]  RST_BOX_WIDTH  = 15'd640;
	localparam logic [DIM_W-1:0]  RST_BOX_HEIGHT = 15'd480;
	localparam logic [SPAN_W-1:0] RST_SPAN       = 31'd6553600;
	localparam logic [MODE_W-1:0] RST_AXIS_MODE  = '0;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_SAT     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

	// Clamp limits on the 17-bit pre-clamp value
	localparam logic signed [PIX_W:0] PIX_MAX = 17'sd32767;
	localparam logic signed [PIX_W:0] PIX_MIN = -17'sd32768;
	localparam logic signed [PIX_W:0] WIDE_MAX = 17'sd65535;
	localparam logic signed [PIX_W:0] WIDE_MIN = 17'sh1_0000;

	// Point and register snapshot carried beside the log units
	typedef struct packed {
		logic signed [PT_W-1:0]  point_x;
		logic signed [PT_W-1:0]  point_y;
		logic signed [BOX_W-1:0] box_left;
		logic signed [BOX_W-1:0] box_top;
		logic [DIM_W-1:0]        box_width;
		logic [DIM_W-1:0]        box_height;
		logic [SPAN_W-1:0]       x_span;
		logic [SPAN_W-1:0]       y_span;
		logic [MODE_W-1:0]       axis_mode;
	} side_t;

	// Origin overrides carried beside the dividers
	typedef struct packed {
		logic                    x_org;
		logic                    y_org;
		logic                    invalid;
		logic signed [BOX_W-1:0] box_left;
		logic signed [YB_W-1:0]  y_base;
	} post_t;

	// Divider result
	typedef struct packed {
		logic [QUOT_W-1:0] quot;
		logic              neg;
		logic              big;
	} divres_t;

	// Clamped coordinate
	typedef struct packed {
		logic signed [PIX_W-1:0] val;
		logic                    sat;
	} sat_t;

	// Result item
	typedef struct packed {
		logic signed [PIX_W-1:0] pixel_x;
		logic signed [PIX_W-1:0] pixel_y;
		logic [STAT_W-1:0]       status;
	} res_t;

	// Clamp a 17-bit value to 16 bits and flag it
	function automatic sat_t sat16(input logic signed [PIX_W:0] v);
		sat_t r;
		if (v > PIX_MAX) begin
			r.val = PIX_MAX[PIX_W-1:0];
			r.sat = 1'b1;
		end else if (v < PIX_MIN) begin
			r.val = PIX_MIN[PIX_W-1:0];
			r.sat = 1'b1;
		end else begin
			r.val = v[PIX_W-1:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cpps_point_if.sv =====
// ----------------------------------------------------------------------------
// cpps_point_if
// Data point channel: valid, ready and a signed Q16.16 x/y pair.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpps_point_if;
	logic                              valid;
	logic                              ready;
	logic signed [cpps_pkg::PT_W-1:0]  point_x;
	logic signed [cpps_pkg::PT_W-1:0]  point_y;

	modport source(output valid, output point_x, output point_y, input ready);
	modport sink(input valid, input point_x, input point_y, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cpps_pixel_if.sv =====
// ----------------------------------------------------------------------------
// cpps_pixel_if
// Pixel channel: valid, ready, pixel coordinates and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpps_pixel_if;
	logic                               valid;
	logic                               ready;
	logic signed [cpps_pkg::PIX_W-1:0]  pixel_x;
	logic signed [cpps_pkg::PIX_W-1:0]  pixel_y;
	logic [cpps_pkg::STAT_W-1:0]        status;

	modport source(output valid, output pixel_x, output pixel_y, output status,
		input ready);
	modport sink(input valid, input pixel_x, input pixel_y, input status,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cpps_log2_pipe.sv =====
// ----------------------------------------------------------------------------
// cpps_log2_pipe
// Pipelined fixed-point log2: one normalize stage, then one squaring stage
// per fraction bit of the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cpps_log2_pipe (
	input  wire logic                                clk,
	input  wire logic                                adv,
	input  wire logic [cpps_pkg::PT_W-1:0]           value,
	output logic signed [cpps_pkg::LOG_W-1:0]        log_val
);
	localparam int LF = cpps_pkg::LOG_FRAC_BITS;
	localparam int MW = cpps_pkg::MANT_W;
	localparam int MSB_W = $clog2(cpps_pkg::PT_W);

	logic [MW-1:0]                        mant_s [0:LF];
	logic [LF-1:0]                        frac_s [0:LF];
	logic signed [cpps_pkg::EXP_W-1:0]    expo_s [0:LF];

	logic [MSB_W-1:0]                     msb;
	logic [cpps_pkg::PT_W-1:0]            shifted;

	// Find the leading one and normalize to Q1.30
	always_comb begin
		msb = '0;
		for (int i = 0; i < cpps_pkg::PT_W; i++) begin
			if (value[i]) begin
				msb = MSB_W'(i);
			end
		end
		if (msb == MSB_W'(cpps_pkg::PT_W - 1)) begin
			shifted = value >> 1;
		end else begin
			shifted = value << (MSB_W'(MW - 1) - msb);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mant_s[0] <= shifted[MW-1:0];
			frac_s[0] <= '0;
			expo_s[0] <= $signed(cpps_pkg::EXP_W'(msb))
				- $signed(cpps_pkg::EXP_W'(cpps_pkg::FRAC_BITS));
		end
	end

	// One fraction bit per stage by squaring the mantissa
	for (genvar k = 1; k <= LF; k++) begin : g_sq
		logic [2*MW-1:0] sq;
		logic [MW:0]     sh;

		always_comb begin
			sq = mant_s[k-1] * mant_s[k-1];
			sh = sq[2*MW-1:MW-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (sh[MW]) begin
					mant_s[k] <= sh[MW:1];
				end else begin
					mant_s[k] <= sh[MW-1:0];
				end
				frac_s[k] <= {frac_s[k-1][LF-2:0], sh[MW]};
				expo_s[k] <= expo_s[k-1];
			end
		end
	end

	assign log_val = $signed({expo_s[LF], frac_s[LF]});

endmodule

`default_nettype wire

// ===== hw/rtl/cpps_div_pipe.sv =====
// ----------------------------------------------------------------------------
// cpps_div_pipe
// Pipelined signed divide by a positive divisor: add or subtract, magnitude,
// range check, then one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cpps_div_pipe (
	input  wire logic                                 clk,
	input  wire logic                                 adv,
	input  wire logic signed [cpps_pkg::NUM_W-1:0]    term_a,
	input  wire logic signed [cpps_pkg::NUM_W-1:0]    term_b,
	input  wire logic                                 sub,
	input  wire logic [cpps_pkg::SPAN_W-1:0]          den,
	output cpps_pkg::divres_t                         res
);
	localparam int NW = cpps_pkg::NUM_W;
	localparam int QW = cpps_pkg::QUOT_W;

	logic signed [NW-1:0]         num_s1;
	logic [cpps_pkg::SPAN_W-1:0]  den_s1;
	logic [NW-1:0]                mag_s2;
	logic                         neg_s2;
	logic [cpps_pkg::SPAN_W-1:0]  den_s2;

	logic [NW-1:0]                rem_s [0:QW];
	logic [QW-1:0]                quo_s [0:QW];
	logic [cpps_pkg::SPAN_W-1:0]  den_s [0:QW];
	logic                         neg_s [0:QW];
	logic                         big_s [0:QW];

	// Form the numerator
	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1 <= sub ? (term_a - term_b) : (term_a + term_b);
			den_s1 <= den;
		end
	end

	// Split into sign and magnitude
	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s2 <= num_s1[NW-1];
			mag_s2 <= num_s1[NW-1] ? NW'(-num_s1) : NW'(num_s1);
			den_s2 <= den_s1;
		end
	end

	// Flag a quotient that needs more than QW bits
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= mag_s2;
			quo_s[0] <= '0;
			den_s[0] <= den_s2;
			neg_s[0] <= neg_s2;
			big_s[0] <= mag_s2 >= (NW'(den_s2) << QW);
		end
	end

	// Restoring division, most significant quotient bit first
	for (genvar k = 1; k <= QW; k++) begin : g_div
		logic [NW-1:0] dsh;
		logic          take;

		always_comb begin
			dsh  = NW'(den_s[k-1]) << (QW - k);
			take = rem_s[k-1] >= dsh;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= take ? (rem_s[k-1] - dsh) : rem_s[k-1];
				quo_s[k] <= {quo_s[k-1][QW-2:0], take};
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
				big_s[k] <= big_s[k-1];
			end
		end
	end

	assign res.quot = quo_s[QW];
	assign res.neg  = neg_s[QW];
	assign res.big  = big_s[QW];

endmodule

`default_nettype wire

// ===== hw/rtl/chart_point_to_pixel_scaler.sv =====
// ----------------------------------------------------------------------------
// chart_point_to_pixel_scaler
// Maps a signed Q16.16 data point to pixel coordinates in a chart box, with
// a linear or log2 scale per axis.
// ----------------------------------------------------------------------------
// Usage:
//   point channel takes one x/y pair per transfer; pixel channel returns one
//   pixel_x/pixel_y/status per point, in order.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
//   it only while no point is in flight.
// Throughput: one point per cycle, sustained unless the output stalls.
// Pipeline: an entry stage, then the log2 units (normalize plus one squaring
//   multiply per fraction bit), a multiply stage, the divider (add or
//   subtract, magnitude, range check and one restoring step per quotient
//   bit) and an output stage.
// Stall: the whole pipeline holds while the two-entry output queue is full
//   and pixel.ready is low; with room in the queue a new point is taken while
//   a finished result still waits.
// Reset: arst_n clears valid bits and the queue and loads the register
//   defaults (640x480 box at 0,0, spans 100.0, both axes linear).
// ----------------------------------------------------------------------------
`default_nettype none
`include "chart_point_to_pixel_scaler_macros.svh"

module chart_point_to_pixel_scaler (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [cpps_pkg::IDX_W-1:0]        cfg_index,
	input  wire logic [cpps_pkg::SPAN_W-1:0]       cfg_data,
	cpps_point_if.sink                             point,
	cpps_pixel_if.source                           pixel
);
	localparam int LS = cpps_pkg::LOG_STAGES;
	localparam int DS = cpps_pkg::DIV_STAGES;
	localparam int PD = cpps_pkg::PIPE_DEPTH;
	localparam int NW = cpps_pkg::NUM_W;

	// Configuration registers
	logic [cpps_pkg::BOX_W-1:0]   box_left_q;
	logic [cpps_pkg::BOX_W-1:0]   box_top_q;
	logic [cpps_pkg::DIM_W-1:0]   box_width_q;
	logic [cpps_pkg::DIM_W-1:0]   box_height_q;
	logic [cpps_pkg::SPAN_W-1:0]  x_span_q;
	logic [cpps_pkg::SPAN_W-1:0]  y_span_q;
	logic [cpps_pkg::MODE_W-1:0]  axis_mode_q;

	// Pipeline
	logic                         adv;
	logic [PD-1:0]                v_s;
	cpps_pkg::side_t              side_s [0:LS];
	cpps_pkg::post_t              post_s [0:DS];

	logic signed [cpps_pkg::LOG_W-1:0] lx, ly, lxs, lys;

	logic signed [NW-1:0]         xa_s19, xb_s19, ya_s19, yb_s19;
	logic [cpps_pkg::SPAN_W-1:0]  xden_s19, yden_s19;

	cpps_pkg::divres_t            xres, yres;

	// Output queue
	cpps_pkg::res_t               fifo_q [0:cpps_pkg::FIFO_DEPTH-1];
	logic                         wr_q, rd_q;
	logic [1:0]                   cnt_q;
	logic                         fifo_push, fifo_pop, fifo_full;
	cpps_pkg::res_t               res_c;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_left_q   <= cpps_pkg::RST_BOX_LEFT;
			box_top_q    <= cpps_pkg::RST_BOX_TOP;
			box_width_q  <= cpps_pkg::RST_BOX_WIDTH;
			box_height_q <= cpps_pkg::RST_BOX_HEIGHT;
			x_span_q     <= cpps_pkg::RST_SPAN;
			y_span_q     <= cpps_pkg::RST_SPAN;
			axis_mode_q  <= cpps_pkg::RST_AXIS_MODE;
		end else if (cfg_we) begin
			case (cfg_index)
				cpps_pkg::CFG_BOX_LEFT:   box_left_q   <= cfg_data[cpps_pkg::BOX_W-1:0];
				cpps_pkg::CFG_BOX_TOP:    box_top_q    <= cfg_data[cpps_pkg::BOX_W-1:0];
				cpps_pkg::CFG_BOX_WIDTH:  box_width_q  <= cfg_data[cpps_pkg::DIM_W-1:0];
				cpps_pkg::CFG_BOX_HEIGHT: box_height_q <= cfg_data[cpps_pkg::DIM_W-1:0];
				cpps_pkg::CFG_X_SPAN:     x_span_q     <= cfg_data;
				cpps_pkg::CFG_Y_SPAN:     y_span_q     <= cfg_data;
				cpps_pkg::CFG_AXIS_MODE:  axis_mode_q  <= cfg_data[cpps_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance everything unless the queue is full and not draining
	assign fifo_full = (cnt_q == 2'(cpps_pkg::FIFO_DEPTH));
	assign adv       = !fifo_full || pixel.ready;
	assign point.ready = adv;

	// Travel valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[PD-2:0], point.valid};
		end
	end

	// Capture the point and a register snapshot, then delay beside the logs
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0].point_x    <= point.point_x;
			side_s[0].point_y    <= point.point_y;
			side_s[0].box_left   <= box_left_q;
			side_s[0].box_top    <= box_top_q;
			side_s[0].box_width  <= box_width_q;
			side_s[0].box_height <= box_height_q;
			side_s[0].x_span     <= x_span_q;
			side_s[0].y_span     <= y_span_q;
			side_s[0].axis_mode  <= axis_mode_q;
			for (int i = 1; i <= LS; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	cpps_log2_pipe u_log_x (
		.clk(clk), .adv(adv), .value(side_s[0].point_x), .log_val(lx)
	);
	cpps_log2_pipe u_log_y (
		.clk(clk), .adv(adv), .value(side_s[0].point_y), .log_val(ly)
	);
	cpps_log2_pipe u_log_xs (
		.clk(clk), .adv(adv), .value({1'b0, side_s[0].x_span}), .log_val(lxs)
	);
	cpps_log2_pipe u_log_ys (
		.clk(clk), .adv(adv), .value({1'b0, side_s[0].y_span}), .log_val(lys)
	);

	// Pick operands per axis mode and multiply
	cpps_pkg::side_t                    sd;
	logic                               x_log, y_log;
	logic                               x_den_ok, y_den_ok, x_org, y_org;
	logic [cpps_pkg::SPAN_W-1:0]        x_den, y_den;
	logic signed [cpps_pkg::VAL_W-1:0]  x_val, y_val;
	logic signed [cpps_pkg::YB_W-1:0]   y_base;

	always_comb begin
		sd     = side_s[LS];
		x_log  = sd.axis_mode[0];
		y_log  = sd.axis_mode[1];
		y_base = cpps_pkg::YB_W'($signed(sd.box_top))
			+ $signed({2'b00, sd.box_height});

		if (x_log) begin
			x_den_ok = (sd.x_span > cpps_pkg::ONE_U) && (lxs > 0);
			x_org    = !x_den_ok || ($signed(sd.point_x) <= cpps_pkg::ONE_S);
			x_val    = cpps_pkg::VAL_W'(lx);
			x_den    = cpps_pkg::SPAN_W'($unsigned(lxs));
		end else begin
			x_den_ok = (sd.x_span != '0);
			x_org    = !x_den_ok;
			x_val    = cpps_pkg::VAL_W'($signed(sd.point_x));
			x_den    = sd.x_span;
		end

		if (y_log) begin
			y_den_ok = (sd.y_span > cpps_pkg::ONE_U) && (lys > 0);
			y_org    = !y_den_ok || ($signed(sd.point_y) <= 0);
			y_val    = cpps_pkg::VAL_W'(ly);
			y_den    = cpps_pkg::SPAN_W'($unsigned(lys));
		end else begin
			y_den_ok = (sd.y_span != '0);
			y_org    = !y_den_ok;
			y_val    = cpps_pkg::VAL_W'($signed(sd.point_y));
			y_den    = sd.y_span;
		end

		// Keep the divider sane on origin points
		if (x_org) begin
			x_den = cpps_pkg::SPAN_W'(1);
		end
		if (y_org) begin
			y_den = cpps_pkg::SPAN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xa_s19   <= $signed(sd.box_left) * $signed({1'b0, x_den});
			xb_s19   <= $signed({1'b0, sd.box_width}) * x_val;
			ya_s19   <= y_base * $signed({1'b0, y_den});
			yb_s19   <= $signed({1'b0, sd.box_height}) * y_val;
			xden_s19 <= x_den;
			yden_s19 <= y_den;
			post_s[0].x_org    <= x_org;
			post_s[0].y_org    <= y_org;
			post_s[0].invalid  <= !x_den_ok || y_org;
			post_s[0].box_left <= sd.box_left;
			post_s[0].y_base   <= y_base;
			for (int i = 1; i <= DS; i++) begin
				post_s[i] <= post_s[i-1];
			end
		end
	end

	cpps_div_pipe u_div_x (
		.clk(clk), .adv(adv), .term_a(xa_s19), .term_b(xb_s19), .sub(1'b0),
		.den(xden_s19), .res(xres)
	);
	cpps_div_pipe u_div_y (
		.clk(clk), .adv(adv), .term_a(ya_s19), .term_b(yb_s19), .sub(1'b1),
		.den(yden_s19), .res(yres)
	);

	// Apply origin overrides, sign and clamp
	logic signed [cpps_pkg::PIX_W:0] xw, yw, xq, yq;
	cpps_pkg::sat_t                  xs, ys;
	cpps_pkg::post_t                 pe;

	always_comb begin
		pe = post_s[DS];
		xq = $signed({1'b0, xres.quot});
		yq = $signed({1'b0, yres.quot});

		if (xres.big) begin
			xw = xres.neg ? cpps_pkg::WIDE_MIN : cpps_pkg::WIDE_MAX;
		end else begin
			xw = xres.neg ? -xq : xq;
		end
		if (pe.x_org) begin
			xw = (cpps_pkg::PIX_W+1)'(pe.box_left);
		end

		if (yres.big) begin
			yw = yres.neg ? cpps_pkg::WIDE_MIN : cpps_pkg::WIDE_MAX;
		end else begin
			yw = yres.neg ? -yq : yq;
		end
		if (pe.y_org) begin
			yw = pe.y_base;
		end

		xs = cpps_pkg::sat16(xw);
		ys = cpps_pkg::sat16(yw);

		res_c.pixel_x = xs.val;
		res_c.pixel_y = ys.val;
		if (pe.invalid) begin
			res_c.status = cpps_pkg::STAT_INVALID;
		end else if (xs.sat || ys.sat) begin
			res_c.status = cpps_pkg::STAT_SAT;
		end else begin
			res_c.status = cpps_pkg::STAT_OK;
		end
	end

	// Output queue: push finished results, pop on transfer
	assign fifo_push = adv && v_s[PD-1];
	assign fifo_pop  = pixel.valid && pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (fifo_push) begin
				wr_q <= !wr_q;
			end
			if (fifo_pop) begin
				rd_q <= !rd_q;
			end
			case ({fifo_push, fifo_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_push) begin
			fifo_q[wr_q] <= res_c;
		end
	end

	assign pixel.valid   = (cnt_q != '0);
	assign pixel.pixel_x = fifo_q[rd_q].pixel_x;
	assign pixel.pixel_y = fifo_q[rd_q].pixel_y;
	assign pixel.status  = fifo_q[rd_q].status;

	`CPPS_ASSERT_IMPL(a_queue_room, clk, arst_n, fifo_push && fifo_full, fifo_pop, "output queue overrun")
	`CPPS_ASSERT_NEXT(a_entry_valid, clk, arst_n, point.valid && point.ready, v_s[0], "accepted point not in pipeline")
	`CPPS_ASSERT_NEXT(a_last_hold, clk, arst_n, v_s[PD-1] && !adv, v_s[PD-1], "stalled result dropped")
	`CPPS_ASSERT_IMPL(a_status_code, clk, arst_n, pixel.valid, pixel.status <= cpps_pkg::STAT_INVALID, "bad status code")

endmodule

`default_nettype wire
